[design/sorted_weight_priority_queue_assert.svh]
// ----------------------------------------------------------------------------
// sorted_weight_priority_queue_assert.svh
// Assertion macros shared by the priority queue RTL. Each expands to a
// concurrent assertion clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_WEIGHT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_WEIGHT_PRIORITY_QUEUE_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define SWPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SWPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/swpq_pkg.sv]
// ----------------------------------------------------------------------------
// swpq_pkg
// Types, codes and default sizes for the sorted weight priority queue.
// ----------------------------------------------------------------------------
package swpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 512;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int TAG_BITS_DEF    = 9;
  localparam int SYM_BITS        = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_POP_RD,
    S_POP_WAIT,
    S_FIND_RD,
    S_FIND_CMP,
    S_RESP
  } state_t;

  // Status of the shared compare unit: stored entry against request.
  typedef struct packed {
    logic gt;      // stored weight above request weight
    logic eq;      // weights equal
    logic sym_eq;  // symbols equal
  } cmp_res_t;

endpackage

[design/swpq_in_if.sv]
// ----------------------------------------------------------------------------
// swpq_in_if
// Command channel of the priority queue: valid/ready plus one command item.
// ----------------------------------------------------------------------------
interface swpq_in_if #(
  parameter int WEIGHT_BITS = swpq_pkg::WEIGHT_BITS_DEF,
  parameter int TAG_BITS    = swpq_pkg::TAG_BITS_DEF
);
  import swpq_pkg::*;

  logic                   valid;
  logic                   ready;
  cmd_t                   command;
  logic [SYM_BITS-1:0]    symbol;
  logic [WEIGHT_BITS-1:0] weight;
  logic [TAG_BITS-1:0]    left_ref;
  logic [TAG_BITS-1:0]    right_ref;

  modport source (output valid, command, symbol, weight, left_ref, right_ref,
                  input ready);
  modport sink   (input valid, command, symbol, weight, left_ref, right_ref,
                  output ready);
endinterface

[design/swpq_out_if.sv]
// ----------------------------------------------------------------------------
// swpq_out_if
// Result channel of the priority queue: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface swpq_out_if #(
  parameter int QUEUE_DEPTH = swpq_pkg::QUEUE_DEPTH_DEF,
  parameter int WEIGHT_BITS = swpq_pkg::WEIGHT_BITS_DEF,
  parameter int TAG_BITS    = swpq_pkg::TAG_BITS_DEF
);
  import swpq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [SYM_BITS-1:0]    out_symbol;
  logic [WEIGHT_BITS-1:0] out_weight;
  logic [TAG_BITS-1:0]    out_left;
  logic [TAG_BITS-1:0]    out_right;
  logic [CNT_W-1:0]       occupancy;
  logic                   overflow;

  modport source (output valid, hit, out_symbol, out_weight, out_left, out_right,
                  occupancy, overflow, input ready);
  modport sink   (input valid, hit, out_symbol, out_weight, out_left, out_right,
                  occupancy, overflow, output ready);
endinterface

[design/sorted_weight_priority_queue.sv]
// After an item is accepted: clear or a dropped insert goes straight to the
// response; pop reads the head, then takes it; find reads and compares each
// entry from the head until a match or the end; insert walks down from the tail.
// One item in process; each scan step reads once on the single RAM read port.
// Synchronous active-low reset empties the queue and the result register;
// the entry RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// sorted_weight_priority_queue
// Bounded queue kept in ascending weight order in a circular RAM. Insert
// walks down from the tail moving entries up one slot; pop reads the head.
// ----------------------------------------------------------------------------
`include "sorted_weight_priority_queue_assert.svh"

module sorted_weight_priority_queue #(
  parameter int QUEUE_DEPTH = swpq_pkg::QUEUE_DEPTH_DEF,
  parameter int WEIGHT_BITS = swpq_pkg::WEIGHT_BITS_DEF,
  parameter int TAG_BITS    = swpq_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swpq_in_if.sink     in_chan,
  swpq_out_if.source  out_chan
);
  import swpq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W = SYM_BITS + WEIGHT_BITS + 2 * TAG_BITS;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;

  logic [SYM_BITS-1:0]    req_sym_r, req_sym_nxt;
  logic [WEIGHT_BITS-1:0] req_wt_r, req_wt_nxt;
  logic [TAG_BITS-1:0]    req_left_r, req_left_nxt;
  logic [TAG_BITS-1:0]    req_right_r, req_right_nxt;

  logic                   res_hit_r, res_hit_nxt;
  logic                   res_ovf_r, res_ovf_nxt;
  logic [SYM_BITS-1:0]    res_sym_r, res_sym_nxt;
  logic [WEIGHT_BITS-1:0] res_wt_r, res_wt_nxt;
  logic [TAG_BITS-1:0]    res_left_r, res_left_nxt;
  logic [TAG_BITS-1:0]    res_right_r, res_right_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r;
  logic                   out_ovf_r;
  logic [SYM_BITS-1:0]    out_sym_r;
  logic [WEIGHT_BITS-1:0] out_wt_r;
  logic [TAG_BITS-1:0]    out_left_r;
  logic [TAG_BITS-1:0]    out_right_r;
  logic [CNT_W-1:0]       out_occ_r;
  logic                   out_load;

  logic                   in_acc;
  logic                   shift;

  logic                   wr_en, rd_en;
  logic [CNT_W-1:0]       wr_log, rd_log;
  logic [PTR_W-1:0]       wr_addr, rd_addr;
  logic [CNT_W:0]         wr_sum, rd_sum;
  logic [DATA_W-1:0]      wr_data, rd_data, new_entry;

  logic [SYM_BITS-1:0]    rd_sym;
  logic [WEIGHT_BITS-1:0] rd_wt;
  logic [TAG_BITS-1:0]    rd_left, rd_right;
  cmp_res_t               cmp_res;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign rd_sym   = rd_data[DATA_W-1 -: SYM_BITS];
  assign rd_wt    = rd_data[2*TAG_BITS +: WEIGHT_BITS];
  assign rd_left  = rd_data[TAG_BITS +: TAG_BITS];
  assign rd_right = rd_data[0 +: TAG_BITS];
  assign new_entry = {req_sym_r, req_wt_r, req_left_r, req_right_r};

  // Logical slot to physical RAM address, wrapping around the head.
  always_comb begin
    wr_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(wr_log);
    if (wr_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    rd_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(rd_log);
    if (rd_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      rd_sum = rd_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
  end
  assign wr_addr = wr_sum[PTR_W-1:0];
  assign rd_addr = rd_sum[PTR_W-1:0];

  swpq_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  swpq_cmp #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_cmp (
    .a_weight (rd_wt),
    .b_weight (req_wt_r),
    .a_sym    (rd_sym),
    .b_sym    (req_sym_r),
    .res      (cmp_res)
  );

  // Move the stored entry up if it belongs after the new one; a tie with
  // the head keeps the head in front.
  assign shift = cmp_res.gt || (cmp_res.eq && (idx_r != CNT_W'(1)));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    req_sym_nxt   = req_sym_r;
    req_wt_nxt    = req_wt_r;
    req_left_nxt  = req_left_r;
    req_right_nxt = req_right_r;
    res_hit_nxt   = res_hit_r;
    res_ovf_nxt   = res_ovf_r;
    res_sym_nxt   = res_sym_r;
    res_wt_nxt    = res_wt_r;
    res_left_nxt  = res_left_r;
    res_right_nxt = res_right_r;
    wr_en         = 1'b0;
    wr_log        = '0;
    wr_data       = new_entry;
    rd_en         = 1'b0;
    rd_log        = '0;
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_sym_nxt   = in_chan.symbol;
          req_wt_nxt    = in_chan.weight;
          req_left_nxt  = in_chan.left_ref;
          req_right_nxt = in_chan.right_ref;
          res_hit_nxt   = 1'b0;
          res_ovf_nxt   = 1'b0;
          res_sym_nxt   = '0;
          res_wt_nxt    = '0;
          res_left_nxt  = '0;
          res_right_nxt = '0;
          unique case (in_chan.command)
            CMD_INSERT: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_ovf_nxt = 1'b1;
                state_nxt   = S_RESP;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            CMD_POP: begin
              state_nxt = (count_r == '0) ? S_RESP : S_POP_RD;
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              head_nxt  = '0;
              state_nxt = S_RESP;
            end
            CMD_FIND: begin
              idx_nxt   = '0;
              state_nxt = S_FIND_RD;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          wr_log    = '0;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_log    = idx_r - CNT_W'(1);
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        wr_en  = 1'b1;
        wr_log = idx_r;
        if (shift) begin
          wr_data   = rd_data;
          idx_nxt   = idx_r - CNT_W'(1);
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_RESP;
        end
      end

      S_POP_RD: begin
        rd_en     = 1'b1;
        rd_log    = '0;
        state_nxt = S_POP_WAIT;
      end

      S_POP_WAIT: begin
        res_hit_nxt   = 1'b1;
        res_sym_nxt   = rd_sym;
        res_wt_nxt    = rd_wt;
        res_left_nxt  = rd_left;
        res_right_nxt = rd_right;
        head_nxt      = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        count_nxt     = count_r - CNT_W'(1);
        state_nxt     = S_RESP;
      end

      S_FIND_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_log    = idx_r;
          state_nxt = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (cmp_res.sym_eq) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_FIND_RD;
        end
      end

      S_RESP: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    req_sym_r   <= req_sym_nxt;
    req_wt_r    <= req_wt_nxt;
    req_left_r  <= req_left_nxt;
    req_right_r <= req_right_nxt;
    res_hit_r   <= res_hit_nxt;
    res_ovf_r   <= res_ovf_nxt;
    res_sym_r   <= res_sym_nxt;
    res_wt_r    <= res_wt_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    if (out_load) begin
      out_hit_r   <= res_hit_r;
      out_ovf_r   <= res_ovf_r;
      out_sym_r   <= res_sym_r;
      out_wt_r    <= res_wt_r;
      out_left_r  <= res_left_r;
      out_right_r <= res_right_r;
      out_occ_r   <= count_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hit        = out_hit_r;
  assign out_chan.overflow   = out_ovf_r;
  assign out_chan.out_symbol = out_sym_r;
  assign out_chan.out_weight = out_wt_r;
  assign out_chan.out_left   = out_left_r;
  assign out_chan.out_right  = out_right_r;
  assign out_chan.occupancy  = out_occ_r;

  `SWPQ_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "entry count beyond depth")
  `SWPQ_ASSERT(a_head_bound, head_r <= PTR_W'(QUEUE_DEPTH - 1), "head pointer out of range")
  `SWPQ_ASSERT_NEXT(a_clear_empties, in_acc && (in_chan.command == CMD_CLEAR), count_r == '0, "clear left entries behind")
  `SWPQ_ASSERT_NEXT(a_shift_steps, (state_r == S_INS_CMP) && shift, idx_r == $past(idx_r) - CNT_W'(1), "insert walk skipped a slot")
  `SWPQ_ASSERT(a_write_in_insert, wr_en |-> ((state_r == S_INS_RD) || (state_r == S_INS_CMP)), "RAM written outside insert")

endmodule

[design/swpq_ram.sv]
// ----------------------------------------------------------------------------
// swpq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swpq_ram #(
  parameter int DEPTH  = swpq_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_W = 42
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/swpq_cmp.sv]
// ----------------------------------------------------------------------------
// swpq_cmp
// Shared compare unit: stored entry weight and symbol against the request.
// ----------------------------------------------------------------------------
module swpq_cmp #(
  parameter int WEIGHT_BITS = swpq_pkg::WEIGHT_BITS_DEF
) (
  input  logic [WEIGHT_BITS-1:0]       a_weight,
  input  logic [WEIGHT_BITS-1:0]       b_weight,
  input  logic [swpq_pkg::SYM_BITS-1:0] a_sym,
  input  logic [swpq_pkg::SYM_BITS-1:0] b_sym,
  output swpq_pkg::cmp_res_t            res
);
  import swpq_pkg::*;

  always_comb begin
    res.gt     = (a_weight > b_weight);
    res.eq     = (a_weight == b_weight);
    res.sym_eq = (a_sym == b_sym);
  end

endmodule
